// ===== rtl/mcf_pkg.sv =====
// ----------------------------------------------------------------------------
// Motion confidence fusion package
// Shared constants, pipeline payload types and the environmental factor table.
// ----------------------------------------------------------------------------
package mcf_pkg;

    // Fixed-point constants, Q1.15, and the battery and temperature limits.
    localparam logic [15:0] Q_ONE         = 16'd32768;
    localparam logic [15:0] K_WILD_WEIGHT = 16'd6554;
    localparam logic [15:0] K_090         = 16'd29491;
    localparam logic [15:0] K_095         = 16'd31130;
    localparam logic [15:0] K_085         = 16'd27853;
    localparam logic [15:0] K_110         = 16'd36045;
    localparam logic [15:0] K_115         = 16'd37683;
    localparam logic [15:0] K_MIN         = 16'd16384;
    localparam logic [15:0] K_MAX         = 16'd39322;
    localparam logic [12:0] BATT_LOW_MV   = 13'd3300;
    localparam logic signed [7:0] TEMP_HIGH = 8'sd40;
    localparam logic [15:0] LIGHT_DARK    = 16'd3277;

    // Widths of the divider datapath.
    localparam int NUM_W  = 34;
    localparam int DEN_W  = 18;
    localparam int QUO_W  = 16;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_PIR_WEIGHT   = 3'd0,
        REG_FRAME_WEIGHT = 3'd1,
        REG_AI_WEIGHT    = 3'd2,
        REG_CAPTURE_THR  = 3'd3,
        REG_TRANSMIT_THR = 3'd4,
        REG_ALERT_THR    = 3'd5,
        REG_ADAPT_MODES  = 3'd6
    } mcf_reg_t;

    // Hour-of-day factor classes.
    typedef enum logic [2:0] {
        HOUR_NONE = 3'd0,
        HOUR_110  = 3'd1,
        HOUR_115  = 3'd2,
        HOUR_090  = 3'd3,
        HOUR_095  = 3'd4
    } mcf_hour_t;

    // Payload that rides alongside the division.
    typedef struct packed {
        logic [15:0] base;
        logic [15:0] env;
        logic        den_zero;
        logic        motion;
        logic        is_wild;
        logic        wild_capture;
        logic        wild_alert;
    } mcf_side_t;

    // State held by one divider cell.
    typedef struct packed {
        logic                 valid;
        logic [DEN_W-1:0]     rem;
        logic [QUO_W-1:0]     low;
        logic [QUO_W-1:0]     quo;
        logic [DEN_W-1:0]     den;
        mcf_side_t            side;
    } mcf_div_t;

    typedef logic [15:0] mcf_env_tab_t [128];

    // Hour class of an hour of day.
    function automatic mcf_hour_t mcf_hour_class(input logic [4:0] h);
        mcf_hour_t c;
        c = HOUR_NONE;
        if (h >= 5'd6 && h <= 5'd8) c = HOUR_110;
        else if (h >= 5'd17 && h <= 5'd19) c = HOUR_115;
        else if (h <= 5'd5) c = HOUR_090;
        else if (h >= 5'd12 && h <= 5'd15) c = HOUR_095;
        return c;
    endfunction

    // Truncating Q1.15 product on constants.
    function automatic int mcf_qmul(input int a, input int k);
        longint p;
        p = longint'(a) * longint'(k);
        return int'(p >>> 15);
    endfunction

    // Factor table indexed by {hour class, battery, temperature, light, weather}.
    function automatic mcf_env_tab_t mcf_build_env();
        mcf_env_tab_t tab;
        int f;
        for (int i = 0; i < 128; i++) begin
            f = int'(Q_ONE);
            if (i[3]) f = mcf_qmul(f, int'(K_090));
            if (i[2]) f = mcf_qmul(f, int'(K_095));
            if (i[1]) f = mcf_qmul(f, int'(K_090));
            if (i[0]) f = mcf_qmul(f, int'(K_085));
            case (i[6:4])
                3'd1: f = mcf_qmul(f, int'(K_110));
                3'd2: f = mcf_qmul(f, int'(K_115));
                3'd3: f = mcf_qmul(f, int'(K_090));
                3'd4: f = mcf_qmul(f, int'(K_095));
                default: f = f;
            endcase
            if (f < int'(K_MIN)) f = int'(K_MIN);
            if (f > int'(K_MAX)) f = int'(K_MAX);
            tab[i] = 16'(f);
        end
        return tab;
    endfunction

endpackage

// ===== rtl/mcf_front.sv =====
// ----------------------------------------------------------------------------
// Motion confidence fusion front end
// Forms the weighted products, the numerator and denominator of the average
// and looks up the environmental factor, in two register stages.
// ----------------------------------------------------------------------------
module mcf_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [103:0]     in_data,
    input  logic [15:0]      pir_weight,
    input  logic [15:0]      frame_weight,
    input  logic [15:0]      ai_weight,
    input  logic [2:0]       adapt_modes,
    output mcf_pkg::mcf_div_t cell_out
);
    import mcf_pkg::*;

    localparam mcf_env_tab_t EnvTab = mcf_build_env();

    // Field unpacking.
    logic [3:0]        detect_flags;
    logic [15:0]       base_confidence;
    logic [15:0]       ml_confidence;
    logic [2:0]        wildlife_flags;
    logic [15:0]       wildlife_confidence;
    logic [12:0]       battery_mv;
    logic signed [7:0] temperature_c;
    logic [15:0]       light_level;
    logic              weather_active;
    logic [4:0]        hour;

    assign detect_flags        = in_data[3:0];
    assign base_confidence     = in_data[19:4];
    assign ml_confidence       = in_data[35:20];
    assign wildlife_flags      = in_data[38:36];
    assign wildlife_confidence = in_data[54:39];
    assign battery_mv          = in_data[67:55];
    assign temperature_c       = in_data[75:68];
    assign light_level         = in_data[91:76];
    assign weather_active      = in_data[92];
    assign hour                = in_data[97:93];

    // Stage one: products, weights in use and the factor table index.
    logic        use_pir, use_frame, use_ai, use_wild;
    logic [6:0]  env_idx;
    mcf_hour_t   hcls;

    logic        s1_valid_reg;
    logic [31:0] p_pir_reg, p_frame_reg, p_ai_reg, p_wild_reg;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [6:0]  env_idx_reg;
    logic        env_on_reg;
    mcf_side_t   side1_reg;

    always_comb
    begin
        use_pir   = detect_flags[1];
        use_frame = detect_flags[2];
        use_ai    = detect_flags[3] && (ml_confidence != 16'd0);
        use_wild  = wildlife_flags[0];
        hcls      = adapt_modes[2] ? mcf_hour_class(hour) : HOUR_NONE;
        env_idx   = {hcls,
                     battery_mv < BATT_LOW_MV,
                     (temperature_c < 8'sd0) || (temperature_c > TEMP_HIGH),
                     light_level < LIGHT_DARK,
                     adapt_modes[1] & weather_active};
        den_next  = (use_pir   ? DEN_W'(pir_weight)    : '0)
                  + (use_frame ? DEN_W'(frame_weight)  : '0)
                  + (use_ai    ? DEN_W'(ai_weight)     : '0)
                  + (use_wild  ? DEN_W'(K_WILD_WEIGHT) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_pir_reg   <= use_pir   ? pir_weight * base_confidence : 32'd0;
            p_frame_reg <= use_frame ? frame_weight * base_confidence : 32'd0;
            p_ai_reg    <= use_ai    ? ai_weight * ml_confidence : 32'd0;
            p_wild_reg  <= use_wild  ? K_WILD_WEIGHT * wildlife_confidence : 32'd0;
            den_reg     <= den_next;
            env_idx_reg <= env_idx;
            env_on_reg  <= adapt_modes[0];
            side1_reg.base         <= base_confidence;
            side1_reg.env          <= Q_ONE;
            side1_reg.den_zero     <= (den_next == '0);
            side1_reg.motion       <= detect_flags[0];
            side1_reg.is_wild      <= wildlife_flags[0];
            side1_reg.wild_capture <= wildlife_flags[1];
            side1_reg.wild_alert   <= wildlife_flags[2];
        end
    end

    // Stage two: numerator sum and factor lookup, loaded into the first cell.
    logic [NUM_W-1:0] num;
    mcf_side_t        side2;
    mcf_div_t         cell_reg;

    assign num = NUM_W'(p_pir_reg) + NUM_W'(p_frame_reg)
               + NUM_W'(p_ai_reg) + NUM_W'(p_wild_reg);

    // The side payload picks up the looked-up factor here.
    always_comb
    begin
        side2     = side1_reg;
        side2.env = env_on_reg ? EnvTab[env_idx_reg] : Q_ONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else if (en)
        begin
            cell_reg.valid <= s1_valid_reg;
            cell_reg.rem   <= num[NUM_W-1:QUO_W];
            cell_reg.low   <= num[QUO_W-1:0];
            cell_reg.quo   <= '0;
            cell_reg.den   <= den_reg;
            cell_reg.side  <= side2;
        end
    end

    assign cell_out = cell_reg;

endmodule

// ===== rtl/mcf_div_cell.sv =====
// ----------------------------------------------------------------------------
// Motion confidence fusion divider cell
// One restoring division step: shifts in one numerator bit, subtracts the
// denominator when it fits and appends one quotient bit.
// ----------------------------------------------------------------------------
module mcf_div_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  mcf_pkg::mcf_div_t cell_in,
    output mcf_pkg::mcf_div_t cell_out
);
    import mcf_pkg::*;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;
    mcf_div_t         cell_reg;

    // Compare and subtract on the shifted partial remainder.
    always_comb
    begin
        trial = {cell_in.rem, cell_in.low[QUO_W-1]};
        diff  = trial - {1'b0, cell_in.den};
        fits  = trial >= {1'b0, cell_in.den};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else if (en)
        begin
            cell_reg.valid <= cell_in.valid;
            cell_reg.rem   <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cell_reg.low   <= {cell_in.low[QUO_W-2:0], 1'b0};
            cell_reg.quo   <= {cell_in.quo[QUO_W-2:0], fits};
            cell_reg.den   <= cell_in.den;
            cell_reg.side  <= cell_in.side;
        end
    end

    assign cell_out = cell_reg;

endmodule

// ===== rtl/mcf_back.sv =====
// ----------------------------------------------------------------------------
// Motion confidence fusion back end
// Scales the fused and base confidences by the factor, saturates, and makes
// the capture, save, transmit and alert decisions into the output register.
// ----------------------------------------------------------------------------
module mcf_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  mcf_pkg::mcf_div_t cell_in,
    input  logic [15:0]       capture_threshold,
    input  logic [15:0]       transmit_threshold,
    input  logic [15:0]       alert_threshold,
    output logic              out_valid,
    output logic [55:0]       out_data
);
    import mcf_pkg::*;

    logic [15:0] fused;
    logic        m_valid_reg;
    logic [31:0] f_prod_reg, b_prod_reg;
    mcf_side_t   side_reg;

    // No weight in use falls back to the base confidence.
    assign fused = cell_in.side.den_zero ? cell_in.side.base : cell_in.quo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= cell_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_prod_reg <= fused * cell_in.side.env;
            b_prod_reg <= cell_in.side.base * cell_in.side.env;
            side_reg   <= cell_in.side;
        end
    end

    // Saturation and decisions.
    logic [15:0] f_out, b_out;
    logic        cap, sav, tx, al;

    always_comb
    begin
        f_out = f_prod_reg[31] ? 16'hFFFF : f_prod_reg[30:15];
        b_out = b_prod_reg[31] ? 16'hFFFF : b_prod_reg[30:15];
        cap   = (f_out >= capture_threshold) && side_reg.motion
              && (!side_reg.is_wild || side_reg.wild_capture);
        sav   = cap && (f_out >= capture_threshold);
        tx    = sav && (f_out >= transmit_threshold);
        al    = (f_out >= alert_threshold) || (side_reg.is_wild && side_reg.wild_alert);
    end

    logic        out_valid_reg;
    logic [55:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= {4'd0, al, tx, sav, cap, side_reg.env, b_out, f_out};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/motion_confidence_fusion.sv =====
// ----------------------------------------------------------------------------
// Motion confidence fusion
// Fuses sensor confidences into one weighted, environment-scaled value and
// derives capture, save, transmit and alert decisions.
// ----------------------------------------------------------------------------
// Usage: one detection event enters per s_tvalid/s_tready transaction and
// exactly one result leaves per m_tvalid/m_tready transaction, in order.
// The cfg channel writes the seven registers by index; it is always ready and
// writes beyond index 6 are dropped. Write it only while the block is idle.
// Pipeline: two front stages (products, sum and factor lookup), a chain of
// 16 divider cells that each resolve one quotient bit, a scaling multiply
// stage and the output register. One event per cycle when not stalled.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so s_tready follows m_tready while a result is held.
// When the receiver stalls, every stage holds its contents and no event is
// lost. Reset empties the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
module motion_confidence_fusion (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // detect_flags, base_confidence, ml_confidence, wildlife_flags,
    // wildlife_confidence, battery_mv, temperature_c, light_level,
    // weather_active, hour, zero fill
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // fused_confidence, adjusted_base, env_factor, do_capture, do_save,
    // do_transmit, do_alert, zero fill
    output logic [55:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import mcf_pkg::*;

    // Configuration registers.
    logic [15:0] pir_weight_reg, frame_weight_reg, ai_weight_reg;
    logic [15:0] capture_thr_reg, transmit_thr_reg, alert_thr_reg;
    logic [2:0]  adapt_modes_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pir_weight_reg   <= 16'd13107;
            frame_weight_reg <= 16'd9830;
            ai_weight_reg    <= 16'd9830;
            capture_thr_reg  <= 16'd19661;
            transmit_thr_reg <= 16'd22938;
            alert_thr_reg    <= 16'd26214;
            adapt_modes_reg  <= 3'd7;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PIR_WEIGHT:   pir_weight_reg   <= cfg_data;
                REG_FRAME_WEIGHT: frame_weight_reg <= cfg_data;
                REG_AI_WEIGHT:    ai_weight_reg    <= cfg_data;
                REG_CAPTURE_THR:  capture_thr_reg  <= cfg_data;
                REG_TRANSMIT_THR: transmit_thr_reg <= cfg_data;
                REG_ALERT_THR:    alert_thr_reg    <= cfg_data;
                REG_ADAPT_MODES:  adapt_modes_reg  <= cfg_data[2:0];
                default:          ;
            endcase
        end
    end

    // Global pipeline advance.
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    mcf_div_t chain [QUO_W+1];

    mcf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (s_tvalid),
        .in_data      (s_tdata),
        .pir_weight   (pir_weight_reg),
        .frame_weight (frame_weight_reg),
        .ai_weight    (ai_weight_reg),
        .adapt_modes  (adapt_modes_reg),
        .cell_out     (chain[0])
    );

    // Divider chain, one quotient bit per cell.
    for (genvar g = 0; g < QUO_W; g++)
    begin : g_cell
        mcf_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .cell_in  (chain[g]),
            .cell_out (chain[g+1])
        );
    end

    mcf_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .en                 (en),
        .cell_in            (chain[QUO_W]),
        .capture_threshold  (capture_thr_reg),
        .transmit_threshold (transmit_thr_reg),
        .alert_threshold    (alert_thr_reg),
        .out_valid          (m_tvalid),
        .out_data           (m_tdata)
    );

    // A delivered factor always lies in the clamp range.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[47:32] >= K_MIN && m_tdata[47:32] <= K_MAX))
        else $error("env_factor outside clamp range");

    // Save needs capture, transmit needs save.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((!m_tdata[49] || m_tdata[48]) && (!m_tdata[50] || m_tdata[49])))
        else $error("decision chain broken");

    // A stalled result stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // The divider quotient never sees a remainder at or above the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (chain[QUO_W].valid && !chain[QUO_W].side.den_zero)
            |-> (chain[QUO_W].rem < chain[QUO_W].den))
        else $error("divider remainder out of range");

endmodule

// ===== verif/fusion_checker.sv =====
// ----------------------------------------------------------------------------
// Motion confidence fusion checker
// Watches the event, result and register channels. It predicts every result
// from its own copy of the registers and compares it field by field.
// ----------------------------------------------------------------------------
module fusion_checker
    import mcf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [103:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [55:0]  m_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] fused;
        logic [15:0] adj_base;
        logic [15:0] env;
        logic        capture;
        logic        save;
        logic        transmit;
        logic        alert;
    } decision_t;

    // Shadow copy of the register file.
    logic [15:0] pir_w, frame_w, ai_w, cap_thr, tx_thr, alert_thr;
    logic [2:0]  modes;

    decision_t expected_q[$];
    int        result_cnt;

    // Truncating Q1.15 product.
    function automatic longint unsigned q15_mul(longint unsigned a, longint unsigned k);
        return (a * k) >> 15;
    endfunction

    function automatic logic [15:0] sat16(longint unsigned v);
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    // Environmental scaling factor of one event.
    function automatic logic [15:0] env_factor(input logic [103:0] d);
        logic [12:0]        batt;
        logic signed [7:0]  temp;
        logic [15:0]        light;
        logic [4:0]         hr;
        longint unsigned    f;
        batt  = d[67:55];
        temp  = d[75:68];
        light = d[91:76];
        hr    = d[97:93];
        f     = Q_ONE;
        if (!modes[0])
            return Q_ONE;
        if (batt < BATT_LOW_MV) f = q15_mul(f, K_090);
        if (temp < 0 || temp > TEMP_HIGH) f = q15_mul(f, K_095);
        if (light < LIGHT_DARK) f = q15_mul(f, K_090);
        if (modes[1] && d[92]) f = q15_mul(f, K_085);
        if (modes[2])
        begin
            if (hr >= 6 && hr <= 8) f = q15_mul(f, K_110);
            else if (hr >= 17 && hr <= 19) f = q15_mul(f, K_115);
            else if (hr <= 5) f = q15_mul(f, K_090);
            else if (hr >= 12 && hr <= 15) f = q15_mul(f, K_095);
        end
        if (f < K_MIN) f = K_MIN;
        if (f > K_MAX) f = K_MAX;
        return f[15:0];
    endfunction

    // Weighted fusion, scaling and decisions for one event.
    function automatic decision_t fuse_event(input logic [103:0] d);
        decision_t       r;
        longint unsigned num, den, avg;
        logic [3:0]      flags;
        logic [15:0]     base, ml, wconf;
        logic [2:0]      wflags;
        flags  = d[3:0];
        base   = d[19:4];
        ml     = d[35:20];
        wflags = d[38:36];
        wconf  = d[54:39];
        num = 0;
        den = 0;
        if (flags[1]) begin num += pir_w * base; den += pir_w; end
        if (flags[2]) begin num += frame_w * base; den += frame_w; end
        if (flags[3] && ml != 0) begin num += ai_w * ml; den += ai_w; end
        if (wflags[0]) begin num += K_WILD_WEIGHT * wconf; den += K_WILD_WEIGHT; end
        avg = (den != 0) ? num / den : base;
        r.env      = env_factor(d);
        r.fused    = sat16(q15_mul(avg, r.env));
        r.adj_base = sat16(q15_mul(base, r.env));
        r.capture  = r.fused >= cap_thr && flags[0] && (!wflags[0] || wflags[1]);
        r.save     = r.capture && r.fused >= cap_thr;
        r.transmit = r.save && r.fused >= tx_thr;
        r.alert    = r.fused >= alert_thr || (wflags[0] && wflags[2]);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH result %0d %s: got %0d, expected %0d", result_cnt, what, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pir_w     <= 16'd13107;
            frame_w   <= 16'd9830;
            ai_w      <= 16'd9830;
            cap_thr   <= 16'd19661;
            tx_thr    <= 16'd22938;
            alert_thr <= 16'd26214;
            modes     <= 3'd7;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // Writes beyond the last register are dropped.
            case (cfg_index)
                REG_PIR_WEIGHT:   pir_w     <= cfg_data;
                REG_FRAME_WEIGHT: frame_w   <= cfg_data;
                REG_AI_WEIGHT:    ai_w      <= cfg_data;
                REG_CAPTURE_THR:  cap_thr   <= cfg_data;
                REG_TRANSMIT_THR: tx_thr    <= cfg_data;
                REG_ALERT_THR:    alert_thr <= cfg_data;
                REG_ADAPT_MODES:  modes     <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Predict on each accepted event, compare on each accepted result.
    always @(posedge clk)
    begin
        decision_t want;
        if (rst_n && s_tvalid && s_tready)
            expected_q = {expected_q, fuse_event(s_tdata)};
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected result count", 1, 0);
            end
            else
            begin
                want = expected_q.pop_front();
                if (m_tdata[15:0] !== want.fused)
                    report_mismatch("fused_confidence", m_tdata[15:0], want.fused);
                if (m_tdata[31:16] !== want.adj_base)
                    report_mismatch("adjusted_base", m_tdata[31:16], want.adj_base);
                if (m_tdata[47:32] !== want.env)
                    report_mismatch("env_factor", m_tdata[47:32], want.env);
                if (m_tdata[48] !== want.capture)
                    report_mismatch("do_capture", m_tdata[48], want.capture);
                if (m_tdata[49] !== want.save)
                    report_mismatch("do_save", m_tdata[49], want.save);
                if (m_tdata[50] !== want.transmit)
                    report_mismatch("do_transmit", m_tdata[50], want.transmit);
                if (m_tdata[51] !== want.alert)
                    report_mismatch("do_alert", m_tdata[51], want.alert);
            end
            result_cnt++;
        end
        pending = expected_q.size();
    end

endmodule

// ===== verif/tb_motion_confidence_fusion.sv =====
// ----------------------------------------------------------------------------
// Motion confidence fusion testbench
// Drives directed and random detection events through several register
// settings and idle patterns; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_motion_confidence_fusion;
    import mcf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int         DRAIN_CYCLES = 30;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [55:0]  m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [15:0]  cfg_data;
    int           fail_count;
    int           pending;

    // Idle pattern, in percent of cycles.
    int send_idle_pct;
    int recv_stall_pct;
    int hold_reqs;
    int hold_seen;
    int hold_cnt;
    int events_sent;

    typedef struct {
        logic [3:0]  flags;
        logic [15:0] base;
        logic [15:0] ml;
        logic [2:0]  wflags;
        logic [15:0] wconf;
        logic [12:0] batt;
        logic [7:0]  temp;
        logic [15:0] light;
        logic        weather;
        logic [4:0]  hr;
    } event_t;

    motion_confidence_fusion u_top (.*);

    fusion_checker u_checker (.*);

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_seen != hold_reqs)
        begin
            hold_seen = hold_reqs;
            hold_cnt  = 300;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [15:0] rand_conf();
        // Mostly in range, sometimes above 1.0 to reach saturation.
        if ($urandom_range(7) == 0)
            return 16'($urandom_range(65535));
        return 16'($urandom_range(32768));
    endfunction

    function automatic event_t rand_event();
        event_t e;
        e.flags   = 4'($urandom_range(15));
        // Mostly events with motion so that decisions are exercised.
        if ($urandom_range(3) != 0) e.flags[0] = 1'b1;
        e.base    = rand_conf();
        e.ml      = ($urandom_range(9) == 0) ? 16'd0 : rand_conf();
        e.wflags  = 3'($urandom_range(7));
        e.wconf   = rand_conf();
        e.batt    = ($urandom_range(1) == 0) ? 13'($urandom_range(3290, 3310))
                                             : 13'($urandom_range(8191));
        e.temp    = ($urandom_range(2) == 0) ? 8'($urandom_range(36, 44))
                                             : 8'($urandom_range(255));
        e.light   = ($urandom_range(2) == 0) ? 16'($urandom_range(3270, 3285))
                                             : rand_conf();
        e.weather = 1'($urandom_range(1));
        e.hr      = ($urandom_range(4) == 0) ? 5'($urandom_range(31))
                                             : 5'($urandom_range(23));
        return e;
    endfunction

    task automatic send_event(input event_t e);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, e.hr, e.weather, e.light, e.temp, e.batt,
                     e.wconf, e.wflags, e.ml, e.base, e.flags};
        do @(posedge clk); while (!s_tready);
        events_sent++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_all(input logic [15:0] pw, input logic [15:0] fw,
                             input logic [15:0] aw, input logic [15:0] ct,
                             input logic [15:0] tt, input logic [15:0] at,
                             input logic [2:0] md);
        write_reg(REG_PIR_WEIGHT, pw);
        write_reg(REG_FRAME_WEIGHT, fw);
        write_reg(REG_AI_WEIGHT, aw);
        write_reg(REG_CAPTURE_THR, ct);
        write_reg(REG_TRANSMIT_THR, tt);
        write_reg(REG_ALERT_THR, at);
        write_reg(REG_ADAPT_MODES, {13'd0, md});
    endtask

    initial
    begin
        event_t e;
        event_t d;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_PIR_WEIGHT;
        cfg_data       = '0;
        hold_reqs      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        events_sent    = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed events under the reset register values.
        d = '{4'h1, 16'd20000, 16'd0, 3'd0, 16'd0, 13'd4000, 8'd20, 16'd20000, 1'b0, 5'd10};
        send_event(d);                                  // no weight in use
        e = d; e.flags = 4'h9; send_event(e);           // AI flagged but zero ML
        e = '{4'h0, 16'd0, 16'd0, 3'd0, 16'd0, 13'd0, 8'd0, 16'd0, 1'b0, 5'd0};
        send_event(e);
        e = '{4'hF, 16'd32768, 16'd32768, 3'd7, 16'd32768, 13'd8191, 8'd127,
              16'd32768, 1'b1, 5'd31};
        send_event(e);
        e = d; e.flags = 4'hF; e.ml = 16'd30000; e.temp = 8'h80; send_event(e);
        e = d; e.temp = 8'd40; send_event(e);
        e = d; e.temp = 8'd41; send_event(e);
        e = d; e.temp = 8'hFF; e.batt = 13'd3299; send_event(e);
        e = d; e.batt = 13'd3300; e.light = 16'd3276; send_event(e);
        e = d; e.light = 16'd3277; e.weather = 1'b1; send_event(e);
        e = d; e.flags = 4'h7;
        e.hr = 5'd5; send_event(e);
        e.hr = 5'd6; send_event(e);
        e.hr = 5'd8; send_event(e);
        e.hr = 5'd9; send_event(e);
        e.hr = 5'd12; send_event(e);
        e.hr = 5'd15; send_event(e);
        e.hr = 5'd17; send_event(e);
        e.hr = 5'd19; send_event(e);
        e.hr = 5'd24; send_event(e);
        // Above 1.0 times a factor above 1.0 saturates.
        e = d; e.flags = 4'h7; e.base = 16'hFFFF; e.hr = 5'd18; send_event(e);
        // Wildlife veto, then wildlife alert with capture allowed.
        e = d; e.flags = 4'h7; e.base = 16'd32000; e.wflags = 3'd1; e.wconf = 16'd30000;
        send_event(e);
        e.wflags = 3'd7; e.base = 16'd1000; e.wconf = 16'd500; send_event(e);
        wait_idle();

        // Random phases, each with its own registers and idle pattern.
        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: ;
                1: write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 3'd0);
                2: write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                             16'hFFFF, 3'd7);
                default:
                begin
                    write_all(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                              16'($urandom_range(65535)), 16'($urandom_range(32768)),
                              16'($urandom_range(36000)), 16'($urandom_range(39322)),
                              3'($urandom_range(7)));
                    write_reg(REG_UNUSED, 16'($urandom_range(65535)));
                end
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            // Hold the receiver off while events keep coming.
            if (ph == 0 || ph == 4)
                hold_reqs <= hold_reqs + 1;
            for (int n = 0; n < 150; n++)
                send_event(rand_event());
            wait_idle();
        end

        $display("Sent %0d events across 7 register settings, with sender gaps,",
                 events_sent);
        $display("receiver stalls and long hold-offs; every result was checked.");
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mcf_pkg.sv
rtl/mcf_front.sv
rtl/mcf_div_cell.sv
rtl/mcf_back.sv
rtl/motion_confidence_fusion.sv
verif/fusion_checker.sv
verif/tb_motion_confidence_fusion.sv
